// ===== sv/m68kea_pkg.sv =====
// Shared codes and types of the 68000 long effective-address unit.
package m68kea_pkg;

   // Kind of operand location reported with each result.
   typedef enum logic [2:0] {
      LOC_DREG = 3'd0,
      LOC_AREG = 3'd1,
      LOC_MEM  = 3'd2,
      LOC_IMM  = 3'd3,
      LOC_SR   = 3'd4
   } loc_kind_type;

   // Item operations carried in the request tuser bit.
   localparam logic OP_COMPUTE = 1'b0;
   localparam logic OP_WRITE   = 1'b1;

   // Addressing-mode bit positions in the legal execute and flag masks.
   typedef enum logic [3:0] {
      EA_DREG    = 4'd0,
      EA_AREG    = 4'd1,
      EA_IND     = 4'd2,
      EA_POSTINC = 4'd3,
      EA_PREDEC  = 4'd4,
      EA_DISP    = 4'd5,
      EA_INDEX   = 4'd6,
      EA_ABSW    = 4'd7,
      EA_ABSL    = 4'd8,
      EA_PCDISP  = 4'd9,
      EA_PCINDEX = 4'd10,
      EA_IMM     = 4'd11,
      EA_SR      = 4'd12
   } ea_bit_type;

   localparam logic [2:0] MODE_EXTENDED = 3'd7;
   localparam logic [2:0] XREG_IMM      = 3'd4;
   localparam int         MASK_W        = 13;
   localparam int         RF_DEPTH      = 16;
   localparam int         RF_AW         = 4;
   localparam int         EXT_LONG_IDX  = 11;

   localparam logic [2:0] ADV_NONE = 3'd0;
   localparam logic [2:0] ADV_WORD = 3'd2;
   localparam logic [2:0] ADV_LONG = 3'd4;

endpackage

// ===== sv/m68kea_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
module m68kea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== sv/m68k_long_effective_address_unit_top.sv =====
// Top level of the 68000 long effective-address unit with its register file.
//
// Requests arrive on the req_ stream: tuser selects a compute item (0) or a
// register write item (1), tdata carries the mode, register, PC, extension
// words, legal masks and the write index and value. Every request produces
// exactly one response on the rsp_ stream: location kind in tuser, the rest
// of the operand description in tdata. Write items answer with all zeros.
//
// The sixteen data and address registers live in a small RAM with two
// registered read ports, one for the base address register and one for the
// index register. A transfer on req_ issues the reads; in the decode stage the
// operand is decoded, post-increment or pre-decrement is written back, and
// the result is loaded into the response register when that stage advances.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single RAM write port; a write that lands in the same cycle as a read
// is forwarded from a bypass register.
//
// Synchronous reset clears the register valid bits, so every register reads
// as zero until written, and empties the pipeline. When the receiver stalls,
// the response holds, one more item waits in the decode stage, and req_tready
// drops once both are full.
module m68k_long_effective_address_unit_top
   import m68kea_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: mode[2:0], reg_num[5:3], instr_pc[37:6], ext_word[53:38],
   // ext_long[85:54], legal_exec_mask[98:86], legal_flag_mask[111:99],
   // write_index[115:112], write_value[147:116], zero fill[151:148]
   input  logic [151:0] req_tdata,
   // tuser: operation[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: location_reg[2:0], operand_address[34:3], immediate_value[66:35],
   // writes_back[67], sets_flags[68], illegal[69], pc_advance[72:70],
   // zero fill[79:73]
   output logic [79:0]  rsp_tdata,
   // tuser: location_kind[2:0]
   output logic [2:0]   rsp_tuser
);

   // Decode stage registers.
   logic                s1_valid_ff;
   logic                s1_op_ff;
   logic [2:0]          s1_mode_ff;
   logic [2:0]          s1_reg_ff;
   logic [31:0]         s1_pc_ff;
   logic [15:0]         s1_ext_ff;
   logic [31:0]         s1_long_ff;
   logic [MASK_W-1:0]   s1_exec_ff;
   logic [MASK_W-1:0]   s1_flag_ff;
   logic [RF_AW-1:0]    s1_widx_ff;
   logic [31:0]         s1_wval_ff;
   logic [RF_AW-1:0]    rd_addr_a_ff;
   logic [RF_AW-1:0]    rd_addr_b_ff;
   logic                rd_valid_a_ff;
   logic                rd_valid_b_ff;

   // Register valid bits and write bypass.
   logic [RF_DEPTH-1:0] rf_valid_ff;
   logic                fwd_valid_ff;
   logic [RF_AW-1:0]    fwd_addr_ff;
   logic [31:0]         fwd_data_ff;

   // Response register.
   logic                rsp_valid_ff;
   loc_kind_type        rsp_kind_ff;
   logic [2:0]          rsp_lreg_ff;
   logic [31:0]         rsp_addr_ff;
   logic [31:0]         rsp_imm_ff;
   logic                rsp_wb_ff;
   logic                rsp_flags_ff;
   logic                rsp_illegal_ff;
   logic [2:0]          rsp_adv_ff;

   loc_kind_type        rsp_kind_in;
   logic [2:0]          rsp_lreg_in;
   logic [31:0]         rsp_addr_in;
   logic [31:0]         rsp_imm_in;
   logic                rsp_wb_in;
   logic                rsp_flags_in;
   logic                rsp_illegal_in;
   logic [2:0]          rsp_adv_in;

   logic                req_accept;
   logic                s1_advance;
   logic [RF_AW-1:0]    rd_addr_a;
   logic [RF_AW-1:0]    rd_addr_b;
   logic [31:0]         ram_data_a;
   logic [31:0]         ram_data_b;
   logic [31:0]         base_reg;
   logic [31:0]         index_reg;
   logic [31:0]         index_val;
   logic [31:0]         index_base;
   logic [31:0]         index_sum;
   logic [31:0]         disp16;
   logic                ok;
   ea_bit_type          ea_bit;
   logic                ram_wr_en;
   logic [RF_AW-1:0]    ram_wr_addr;
   logic [31:0]         ram_wr_data;

   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   // Port A reads the base address register, port B the index register.
   assign rd_addr_a = {1'b1, req_tdata[5:3]};
   assign rd_addr_b = req_tdata[53:50];

   m68kea_ram #(
      .WIDTH(32),
      .DEPTH(RF_DEPTH)
   ) u_regfile (
      .clock    (clock),
      .wr_en    (ram_wr_en),
      .wr_addr  (ram_wr_addr),
      .wr_data  (ram_wr_data),
      .rd_en    (req_accept),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(ram_data_a),
      .rd_data_b(ram_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff      <= req_tuser;
         s1_mode_ff    <= req_tdata[2:0];
         s1_reg_ff     <= req_tdata[5:3];
         s1_pc_ff      <= req_tdata[37:6];
         s1_ext_ff     <= req_tdata[53:38];
         s1_long_ff    <= req_tdata[85:54];
         s1_exec_ff    <= req_tdata[98:86];
         s1_flag_ff    <= req_tdata[111:99];
         s1_widx_ff    <= req_tdata[115:112];
         s1_wval_ff    <= req_tdata[147:116];
         rd_addr_a_ff  <= rd_addr_a;
         rd_addr_b_ff  <= rd_addr_b;
         rd_valid_a_ff <= rf_valid_ff[rd_addr_a];
         rd_valid_b_ff <= rf_valid_ff[rd_addr_b];
      end
   end

   // The RAM returns the old word when a write lands at the read edge; the
   // bypass always holds the latest write and takes precedence.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_a_ff)) begin
         base_reg = fwd_data_ff;
      end else begin
         base_reg = rd_valid_a_ff ? ram_data_a : 32'd0;
      end
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_b_ff)) begin
         index_reg = fwd_data_ff;
      end else begin
         index_reg = rd_valid_b_ff ? ram_data_b : 32'd0;
      end
   end

   assign disp16     = {{16{s1_ext_ff[15]}}, s1_ext_ff};
   assign index_val  = s1_ext_ff[EXT_LONG_IDX] ? index_reg
                                               : {{16{index_reg[15]}}, index_reg[15:0]};
   assign index_base = (s1_mode_ff == MODE_EXTENDED) ? s1_pc_ff : base_reg;
   assign index_sum  = index_base + {{24{s1_ext_ff[7]}}, s1_ext_ff[7:0]} + index_val;

   // Pick the mask bit that governs this mode.
   always_comb begin
      ea_bit = EA_DREG;
      ok     = 1'b0;
      if (s1_mode_ff != MODE_EXTENDED) begin
         ea_bit = ea_bit_type'({1'b0, s1_mode_ff});
         ok     = s1_exec_ff[s1_mode_ff];
      end else if (s1_reg_ff < XREG_IMM) begin
         ea_bit = ea_bit_type'(4'd7 + {2'b00, s1_reg_ff[1:0]});
         ok     = s1_exec_ff[4'd7 + {2'b00, s1_reg_ff[1:0]}];
      end else if (s1_reg_ff == XREG_IMM) begin
         if (s1_exec_ff[EA_IMM]) begin
            ea_bit = EA_IMM;
            ok     = 1'b1;
         end else if (s1_exec_ff[EA_SR]) begin
            ea_bit = EA_SR;
            ok     = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_kind_in    = LOC_DREG;
      rsp_lreg_in    = 3'd0;
      rsp_addr_in    = 32'd0;
      rsp_imm_in     = 32'd0;
      rsp_wb_in      = 1'b0;
      rsp_flags_in   = 1'b0;
      rsp_illegal_in = 1'b0;
      rsp_adv_in     = ADV_NONE;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = s1_widx_ff;
      ram_wr_data    = s1_wval_ff;
      if (s1_op_ff == OP_WRITE) begin
         ram_wr_en = s1_valid_ff && s1_advance;
      end else if (!ok) begin
         rsp_illegal_in = 1'b1;
      end else begin
         rsp_wb_in    = 1'b1;
         rsp_flags_in = (ea_bit == EA_SR) ? 1'b0 : s1_flag_ff[ea_bit];
         ram_wr_addr  = {1'b1, s1_reg_ff};
         case (ea_bit)
            EA_DREG: begin
               rsp_kind_in = LOC_DREG;
               rsp_lreg_in = s1_reg_ff;
            end
            EA_AREG: begin
               rsp_kind_in = LOC_AREG;
               rsp_lreg_in = s1_reg_ff;
            end
            EA_IND: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = base_reg;
            end
            EA_POSTINC: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = base_reg;
               ram_wr_data = base_reg + 32'd4;
               ram_wr_en   = s1_valid_ff && s1_advance;
            end
            EA_PREDEC: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = base_reg - 32'd4;
               ram_wr_data = base_reg - 32'd4;
               ram_wr_en   = s1_valid_ff && s1_advance;
            end
            EA_DISP: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = base_reg + disp16;
               rsp_adv_in  = ADV_WORD;
            end
            EA_INDEX: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = index_sum;
               rsp_adv_in  = ADV_WORD;
            end
            EA_ABSW: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = disp16;
               rsp_adv_in  = ADV_WORD;
            end
            EA_ABSL: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = s1_long_ff;
               rsp_adv_in  = ADV_LONG;
            end
            EA_PCDISP: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = s1_pc_ff + disp16;
               rsp_adv_in  = ADV_WORD;
               rsp_wb_in   = 1'b0;
            end
            EA_PCINDEX: begin
               rsp_kind_in = LOC_MEM;
               rsp_addr_in = index_sum;
               rsp_adv_in  = ADV_WORD;
               rsp_wb_in   = 1'b0;
            end
            EA_IMM: begin
               rsp_kind_in = LOC_IMM;
               rsp_imm_in  = s1_long_ff;
               rsp_adv_in  = ADV_LONG;
               rsp_wb_in   = 1'b0;
            end
            default: begin
               rsp_kind_in = LOC_SR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (ram_wr_en) begin
         rf_valid_ff[ram_wr_addr] <= 1'b1;
         fwd_valid_ff             <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         fwd_addr_ff <= ram_wr_addr;
         fwd_data_ff <= ram_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_lreg_ff    <= rsp_lreg_in;
         rsp_addr_ff    <= rsp_addr_in;
         rsp_imm_ff     <= rsp_imm_in;
         rsp_wb_ff      <= rsp_wb_in;
         rsp_flags_ff   <= rsp_flags_in;
         rsp_illegal_ff <= rsp_illegal_in;
         rsp_adv_ff     <= rsp_adv_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'd0, rsp_adv_ff, rsp_illegal_ff, rsp_flags_ff, rsp_wb_ff,
                        rsp_imm_ff, rsp_addr_ff, rsp_lreg_ff};

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // The register file changes only when the decode stage hands off its item.
   a_write_on_advance: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (s1_valid_ff && s1_advance))
      else $error("register write without a decode hand-off");

   // The bypass captures every register write.
   a_bypass_tracks: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (fwd_valid_ff && (fwd_addr_ff == $past(ram_wr_addr))
                     && (fwd_data_ff == $past(ram_wr_data))))
      else $error("bypass missed a register write");

   // An illegal result carries no location and no extension.
   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_illegal_ff) |-> ((rsp_kind_ff == LOC_DREG) && (rsp_addr_ff == 32'd0)
                                          && !rsp_wb_ff && (rsp_adv_ff == ADV_NONE)))
      else $error("illegal result with operand fields set");

   // The PC advance is always a whole number of extension words.
   a_adv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_adv_ff == ADV_NONE) || (rsp_adv_ff == ADV_WORD)
                      || (rsp_adv_ff == ADV_LONG)))
      else $error("pc advance out of range");

endmodule
